[src/lru_sector_cache_directory_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sector cache directory
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef LRU_SECTOR_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_SECTOR_CACHE_DIRECTORY_ASSERT_SVH

// The property holds at every rising clock edge outside reset.
`define LSCD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lscd assertion failed");

// When the antecedent holds, the consequent holds in the following cycle.
`define LSCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lscd assertion failed");

`endif

[src/lscd_pkg.sv]
// ----------------------------------------------------------------------------
// Sector cache directory package
// Sizes and types shared by the directory, its channels and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lscd_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int TAG_W   = 28;
   localparam int AGE_W   = 32;
   localparam int WAY_W   = 4;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } entry_type;

endpackage

`default_nettype wire

[src/lscd_if.sv]
// ----------------------------------------------------------------------------
// Sector cache directory channels
// Valid/ready channels for sector requests and lookup results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lscd_req_if
   import lscd_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [TAG_W-1:0] sector;

   modport source (output valid, output sector, input ready);
   modport sink (input valid, input sector, output ready);
endinterface

interface lscd_rsp_if
   import lscd_pkg::*;
;
   logic             valid;
   logic             ready;
   logic             hit;
   logic [WAY_W-1:0] way;

   modport source (output valid, output hit, output way, input ready);
   modport sink (input valid, input hit, input way, output ready);
endinterface

`default_nettype wire

[src/lru_sector_cache_directory.sv]
// ----------------------------------------------------------------------------
// LRU sector cache directory
// Fully associative tag directory with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// Each request item carries a sector number and returns one result item with
// a hit flag and the way that now holds the sector. Tags and ages live in a
// single-port-read, single-port-write entry memory that is scanned one entry
// per cycle. After the scan, a write step updates the chosen entry and
// registers the result; one item is worked on at a time, so a new item is
// accepted only once the last one has passed its write step.
// A finished result waits in an output register while the next item is
// accepted; the next item's write step stalls until that result is taken.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed
// and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_sector_cache_directory
   import lscd_pkg::*;
(
   input wire         clock,
   input wire         reset,
   lscd_req_if.sink   req_ch,
   lscd_rsp_if.source rsp_ch
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;

   entry_type mem [ENTRIES];

   logic [1:0]         state_ff,     state_in;
   logic [TAG_W-1:0]   sector_ff,    sector_in;
   logic [CNT_W-1:0]   cnt_ff,       cnt_in;
   logic               rd_pend_ff,   rd_pend_in;
   logic [IDX_W-1:0]   rd_idx_ff,    rd_idx_in;
   logic               found_ff,     found_in;
   logic [IDX_W-1:0]   hit_way_ff,   hit_way_in;
   logic [IDX_W-1:0]   victim_ff,    victim_in;
   logic [AGE_W-1:0]   min_age_ff,   min_age_in;
   logic [AGE_W-1:0]   tick_ff,      tick_in;
   logic [ENTRIES-1:0] valid_ff,     valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff,   rsp_hit_in;
   logic [WAY_W-1:0]   rsp_way_ff,   rsp_way_in;

   entry_type          rd_data_ff;
   logic               rd_valid_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic [AGE_W-1:0]   age_eff;
   logic               match;

   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign age_eff = rd_valid_ff ? rd_data_ff.age : '0;
   assign match   = rd_valid_ff && (rd_data_ff.tag == sector_ff);

   always_comb begin
      state_in     = state_ff;
      sector_in    = sector_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      hit_way_in   = hit_way_ff;
      victim_in    = victim_ff;
      min_age_in   = min_age_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_way_in   = rsp_way_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = victim_ff;
      wr_data.tag  = sector_ff;
      wr_data.age  = tick_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               sector_in = req_ch.sector;
               cnt_in    = '0;
               found_in  = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff < CNT_W'(ENTRIES)) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = rd_addr;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               if (!found_ff && match) begin
                  found_in   = 1'b1;
                  hit_way_in = rd_idx_ff;
               end
               if (rd_idx_ff == '0 || age_eff < min_age_ff) begin
                  min_age_in = age_eff;
                  victim_in  = rd_idx_ff;
               end
               if (rd_idx_ff == IDX_W'(ENTRIES - 1)) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               wr_en        = 1'b1;
               tick_in      = tick_ff + AGE_W'(1);
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  wr_addr     = hit_way_ff;
                  wr_data.age = tick_ff + AGE_W'(1);
                  rsp_hit_in  = 1'b1;
                  rsp_way_in  = WAY_W'(hit_way_ff);
               end else begin
                  valid_in[victim_ff] = 1'b1;
                  rsp_hit_in          = 1'b0;
                  rsp_way_in          = WAY_W'(victim_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         tick_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sector_ff  <= sector_in;
      cnt_ff     <= cnt_in;
      rd_idx_ff  <= rd_idx_in;
      found_ff   <= found_in;
      hit_way_ff <= hit_way_in;
      victim_ff  <= victim_in;
      min_age_ff <= min_age_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_way_ff <= rsp_way_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hit   = rsp_hit_ff;
   assign rsp_ch.way   = rsp_way_ff;

endmodule

`default_nettype wire

[src/lscd_checker.sv]
// ----------------------------------------------------------------------------
// Sector cache directory checker
// Port-level checks on the request and result channels of the directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_sector_cache_directory_assert.svh"

module lscd_checker
   import lscd_pkg::*;
(
   input wire             clock,
   input wire             reset,
   input wire             req_valid,
   input wire             req_ready,
   input wire             rsp_valid,
   input wire             rsp_ready,
   input wire             rsp_hit,
   input wire [WAY_W-1:0] rsp_way
);

   logic req_seen;
   logic rsp_wait;

   assign req_seen = req_valid && req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;

   `LSCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid)
   `LSCD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_hit) && $stable(rsp_way))
   `LSCD_ASSERT_NEXT(a_one_in_flight, clock, reset, req_seen, !req_ready)
   `LSCD_ASSERT(a_rsp_after_work, clock, reset, !$rose(rsp_valid) || !$past(req_ready))
   `LSCD_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_seen && !rsp_valid, !rsp_valid)

endmodule

bind lru_sector_cache_directory lscd_checker u_lscd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_hit    (rsp_ch.hit),
   .rsp_way    (rsp_ch.way)
);

`default_nettype wire

[tb/lscd_lookup_check.sv]
// ----------------------------------------------------------------------------
// Sector cache directory lookup checker
// Watches the request and result channels and keeps its own copy of the
// directory: tags, valid bits, ages and the tick. It works out the hit flag
// and way for every accepted request and compares each accepted result with
// the oldest outstanding lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscd_lookup_check
   import lscd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lscd_req_if  req_ch,
   lscd_rsp_if  rsp_ch,
   output int   error_count,
   output int   pending_count,
   output int   hit_count,
   output int   miss_count
);

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
   } lookup_type;

   logic [TAG_W-1:0] tag_mem [ENTRIES];
   logic             valid_mem [ENTRIES];
   logic [AGE_W-1:0] age_mem [ENTRIES];
   logic [AGE_W-1:0] tick;
   lookup_type       lookup_q [$];
   int               mismatches;
   int               hits;
   int               misses;

   function automatic lookup_type look_up_sector(input logic [TAG_W-1:0] sector);
      lookup_type res;
      int         victim;
      for (int k = 0; k < ENTRIES; k++) begin
         if (valid_mem[k] && tag_mem[k] == sector) begin
            tick       = tick + AGE_W'(1);
            age_mem[k] = tick;
            res.hit    = 1'b1;
            res.way    = WAY_W'(k);
            return res;
         end
      end
      victim = 0;
      for (int k = 1; k < ENTRIES; k++) begin
         if (age_mem[k] < age_mem[victim]) begin
            victim = k;
         end
      end
      age_mem[victim]   = tick;
      tag_mem[victim]   = sector;
      valid_mem[victim] = 1'b1;
      tick              = tick + AGE_W'(1);
      res.hit           = 1'b0;
      res.way           = WAY_W'(victim);
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_type want;
      if (reset) begin
         for (int k = 0; k < ENTRIES; k++) begin
            tag_mem[k]   = '0;
            valid_mem[k] = 1'b0;
            age_mem[k]   = '0;
         end
         tick = '0;
         lookup_q.delete();
         mismatches = 0;
         hits       = 0;
         misses     = 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (lookup_q.size() == 0) begin
               $error("result item with no request outstanding: hit=%0b way=%0d",
                      rsp_ch.hit, rsp_ch.way);
               mismatches++;
            end else begin
               want = lookup_q.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
                  mismatches++;
               end
               if (rsp_ch.way !== want.way) begin
                  $error("way: expected %0d, got %0d", want.way, rsp_ch.way);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            want = look_up_sector(req_ch.sector);
            lookup_q.push_back(want);
            if (want.hit) begin
               hits++;
            end else begin
               misses++;
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= lookup_q.size();
      hit_count     <= hits;
      miss_count    <= misses;
   end

endmodule

[tb/lru_sector_cache_directory_tb.sv]
// ----------------------------------------------------------------------------
// Sector cache directory testbench
// Sends a short directed run of sector requests (extreme sectors, repeated
// hits, a full set of fills and the evictions that follow), then about a
// thousand random requests drawn mostly from a small working set so that
// hits and LRU evictions are frequent. The sender works in bursts and the
// receiver stalls on its own pattern, with one long hold-off that backs the
// block up. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_sector_cache_directory_tb;

   import lscd_pkg::*;

   localparam int RANDOM_ITEMS = 1000;
   localparam int POOL_SIZE    = 24;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_MOSTLY,
      RSP_RARELY
   } rsp_mode_type;

   logic clock = 1'b0;
   logic reset;
   int   items_sent = 0;
   int   burst_left = 0;
   int   error_count;
   int   pending_count;
   int   hit_count;
   int   miss_count;

   lscd_req_if req_ch ();
   lscd_rsp_if rsp_ch ();

   lru_sector_cache_directory dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lscd_lookup_check u_lookup_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count),
      .hit_count     (hit_count),
      .miss_count    (miss_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_sector(input logic [TAG_W-1:0] sector);
      int gap;
      req_ch.valid  <= 1'b1;
      req_ch.sector <= sector;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      rsp_mode_type mode;
      int           mode_left;
      int           hold_left;
      bit           hold_done;
      logic         ready_next;
      mode      = RSP_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            ready_next = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rsp_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 120);
            end else begin
               mode_left--;
            end
            case (mode)
               RSP_ALWAYS: ready_next = 1'b1;
               RSP_MOSTLY: ready_next = ($urandom_range(0, 3) != 0);
               default:    ready_next = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ch.ready <= ready_next;
      end
   end

   initial begin
      logic [TAG_W-1:0] pool [POOL_SIZE];
      logic [TAG_W-1:0] sector;
      int               pick;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sector <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_sector('0);
      send_sector('1);
      send_sector('1);
      for (int k = 0; k < 16; k++) begin
         send_sector(TAG_W'(1) << (k + 8));
      end
      send_sector('0);
      send_sector('1);
      send_sector(TAG_W'(1) << 8);
      send_sector(TAG_W'(1) << 12);

      foreach (pool[i]) begin
         pool[i] = TAG_W'($urandom);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 19) == 0) begin
            pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_W'($urandom);
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            sector = pool[$urandom_range(0, 13)];
         end else if (pick < 8) begin
            sector = pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            sector = TAG_W'($urandom);
         end
         send_sector(sector);
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d sector requests: %0d hits and %0d fills,", items_sent,
               hit_count, miss_count);
      $display("with bursty requests, random result stalls and one %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
